// ===== sv/spo_pkg.sv =====
// Shared types and constants for the sweep-and-prune overlap pair block.
// Depends on nothing; imported by every module of the block.
package spo_pkg;

    localparam int DEF_MAX_OBJECTS = 8;
    localparam int DEF_COORD_WIDTH = 16;
    localparam int DEF_ID_WIDTH    = 8;
    localparam int STAMP_W         = 32;
    localparam int MAX_PAIRS       = 28;
    localparam int PAIR_W          = $clog2(MAX_PAIRS + 1);

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_UPDATE = 2'd2,
        K_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_DONE   = 3'd0,
        STAT_ABSENT = 3'd1,
        STAT_REJECT = 3'd2,
        STAT_PAIR   = 3'd3,
        STAT_NONE   = 3'd4
    } status_t;

    // Result push from the sequencer to the output stage
    typedef struct packed {
        logic    push;
        status_t status;
        logic    last;
    } push_t;

endpackage

// ===== sv/spo_cmp.sv =====
// Shared magnitude comparator used for edge placement, stamp ranking and y tests.
// Depends on spo_pkg.
module spo_cmp import spo_pkg::*; #(
    parameter int W = 36
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         lt
);

    // Unsigned less-than on pre-biased keys
    assign lt = (a < b);

endmodule

// ===== sv/spo_ctrl.sv =====
// Sequencer and storage: slot table, sorted edge list, stamp ranking and sweep.
// Depends on spo_pkg and spo_cmp.
module spo_ctrl import spo_pkg::*; #(
    parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic [ID_WIDTH-1:0]    s_object_id,
    input  logic [COORD_WIDTH-1:0] s_left_x,
    input  logic [COORD_WIDTH-1:0] s_right_x,
    input  logic [COORD_WIDTH-1:0] s_bottom_y,
    input  logic [COORD_WIDTH-1:0] s_top_y,
    input  logic                   out_free,
    output push_t                  push,
    output logic [ID_WIDTH-1:0]    push_first,
    output logic [ID_WIDTH-1:0]    push_second
);

    localparam int N      = MAX_OBJECTS;
    localparam int SLOT_W = (N > 1) ? $clog2(N) : 1;
    localparam int CNT_W  = $clog2(N + 1);
    localparam int EDGES  = 2 * N;
    localparam int EIDX_W = $clog2(EDGES);
    localparam int ECNT_W = $clog2(EDGES + 1);
    localparam int CW     = COORD_WIDTH;
    localparam int KEY_W  = STAMP_W + SLOT_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FIND, ST_DROP, ST_PUT, ST_RANK, ST_SWEEP,
        ST_CAND, ST_Y2, ST_PAIR, ST_QEND, ST_RESP
    } state_t;

    state_t state_reg;

    // Latched request
    kind_t            kind_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [CW-1:0]    lx_reg, rx_reg, by_reg, ty_reg;

    // Slot table
    logic [N-1:0]        slot_valid_reg;
    logic [ID_WIDTH-1:0] slot_handle_reg [N];
    logic [CW-1:0]       slot_ylo_reg [N];
    logic [CW-1:0]       slot_yhi_reg [N];
    logic [STAMP_W-1:0]  slot_stamp_reg [N];

    // Sorted edge list
    logic [CW-1:0]     edge_pos_reg  [EDGES];
    logic [SLOT_W-1:0] edge_slot_reg [EDGES];
    logic              edge_beg_reg  [EDGES];
    logic [ECNT_W-1:0] edge_count_reg;

    logic [STAMP_W-1:0] stamp_counter_reg;
    logic [N-1:0]       active_mask_reg;

    // Stamp order of valid slots
    logic [SLOT_W-1:0] ord_reg [N];
    logic [CNT_W-1:0]  vcnt_reg;
    logic [CNT_W-1:0]  rank_reg;
    logic [SLOT_W-1:0] t_reg, u_reg;

    // Walk pointers
    logic [ECNT_W-1:0] i_reg, r_reg, w_reg, e_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              phase_reg;
    logic [PAIR_W-1:0] pairs_reg;
    status_t           resp_reg;

    // Held pair, sent once the next one shows it is not the last
    logic                pend_valid_reg;
    logic [ID_WIDTH-1:0] pend_first_reg, pend_second_reg;

    function automatic logic [KEY_W-1:0] ckey(input logic [CW-1:0] c);
        ckey = {{(KEY_W-CW){1'b0}}, ~c[CW-1], c[CW-2:0]};
    endfunction

    // Lookup by id, lowest free slot, count of valid slots
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              has_free;
    logic [SLOT_W-1:0] free_slot;
    logic [CNT_W-1:0]  vcount;

    always_comb begin
        hit = 1'b0;
        hit_slot = '0;
        has_free = 1'b0;
        free_slot = '0;
        vcount = '0;
        for (int s = N - 1; s >= 0; s--) begin
            if (slot_valid_reg[s] && slot_handle_reg[s] == id_reg) begin
                hit = 1'b1;
                hit_slot = SLOT_W'(s);
            end
            if (!slot_valid_reg[s]) begin
                has_free = 1'b1;
                free_slot = SLOT_W'(s);
            end
            vcount = vcount + CNT_W'(slot_valid_reg[s]);
        end
    end

    logic [EIDX_W-1:0] i_idx, i_m1, r_idx, w_idx, e_idx;
    logic [SLOT_W-1:0] a_slot;
    logic [CW-1:0]     new_pos;
    logic [CNT_W-1:0]  rank_fin;
    logic [KEY_W-1:0]  cmp_a, cmp_b;
    logic              lt;

    assign i_idx   = i_reg[EIDX_W-1:0];
    assign i_m1    = EIDX_W'(i_reg - 1'b1);
    assign r_idx   = r_reg[EIDX_W-1:0];
    assign w_idx   = w_reg[EIDX_W-1:0];
    assign e_idx   = e_reg[EIDX_W-1:0];
    assign a_slot  = ord_reg[k_reg[SLOT_W-1:0]];
    assign new_pos = phase_reg ? rx_reg : lx_reg;

    // Operand select for the shared comparator
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        case (state_reg)
            ST_PUT: begin
                cmp_a = ckey(new_pos);
                cmp_b = ckey(edge_pos_reg[i_m1]);
            end
            ST_RANK: begin
                cmp_a = {slot_stamp_reg[u_reg], u_reg};
                cmp_b = {slot_stamp_reg[t_reg], t_reg};
            end
            ST_CAND: begin
                cmp_a = ckey(slot_ylo_reg[a_slot]);
                cmp_b = ckey(slot_yhi_reg[cur_reg]);
            end
            ST_Y2: begin
                cmp_a = ckey(slot_ylo_reg[cur_reg]);
                cmp_b = ckey(slot_yhi_reg[a_slot]);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    spo_cmp #(.W(KEY_W)) u_cmp (.a(cmp_a), .b(cmp_b), .lt(lt));

    assign rank_fin = rank_reg + CNT_W'(slot_valid_reg[u_reg] && lt);

    assign s_ready = (state_reg == ST_IDLE);

    // Result push toward the output stage
    always_comb begin
        push.push   = 1'b0;
        push.status = STAT_DONE;
        push.last   = 1'b0;
        push_first  = '0;
        push_second = '0;
        case (state_reg)
            ST_RESP: begin
                push.push   = out_free;
                push.status = resp_reg;
                push.last   = 1'b1;
            end
            ST_PAIR: begin
                push.push   = out_free && pend_valid_reg;
                push.status = STAT_PAIR;
                push_first  = pend_first_reg;
                push_second = pend_second_reg;
            end
            ST_QEND: begin
                push.push   = out_free;
                push.status = pend_valid_reg ? STAT_PAIR : STAT_NONE;
                push.last   = 1'b1;
                push_first  = pend_valid_reg ? pend_first_reg : '0;
                push_second = pend_valid_reg ? pend_second_reg : '0;
            end
            default: begin
                push.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            slot_valid_reg    <= '0;
            edge_count_reg    <= '0;
            stamp_counter_reg <= '0;
            active_mask_reg   <= '0;
            pend_valid_reg    <= 1'b0;
        end else begin
            case (state_reg)
                // Take a request
                ST_IDLE: begin
                    if (s_valid) begin
                        kind_reg  <= kind_t'(s_kind);
                        id_reg    <= s_object_id;
                        lx_reg    <= s_left_x;
                        rx_reg    <= s_right_x;
                        by_reg    <= s_bottom_y;
                        ty_reg    <= s_top_y;
                        state_reg <= ST_FIND;
                    end
                end
                // Dispatch on kind and lookup result
                ST_FIND: begin
                    phase_reg <= 1'b0;
                    if (kind_reg == K_QUERY) begin
                        active_mask_reg <= '0;
                        pend_valid_reg  <= 1'b0;
                        pairs_reg       <= '0;
                        vcnt_reg        <= vcount;
                        rank_reg        <= '0;
                        t_reg           <= '0;
                        u_reg           <= '0;
                        state_reg       <= ST_RANK;
                    end else if (kind_reg == K_INSERT) begin
                        if (hit || !has_free) begin
                            resp_reg  <= STAT_REJECT;
                            state_reg <= ST_RESP;
                        end else begin
                            cur_reg                    <= free_slot;
                            slot_valid_reg[free_slot]  <= 1'b1;
                            slot_handle_reg[free_slot] <= id_reg;
                            slot_ylo_reg[free_slot]    <= by_reg;
                            slot_yhi_reg[free_slot]    <= ty_reg;
                            slot_stamp_reg[free_slot]  <= stamp_counter_reg;
                            stamp_counter_reg          <= stamp_counter_reg + 1'b1;
                            i_reg                      <= edge_count_reg;
                            state_reg                  <= ST_PUT;
                        end
                    end else if (!hit) begin
                        resp_reg  <= STAT_ABSENT;
                        state_reg <= ST_RESP;
                    end else begin
                        cur_reg   <= hit_slot;
                        r_reg     <= '0;
                        w_reg     <= '0;
                        state_reg <= ST_DROP;
                    end
                end
                // Compact the edge list, dropping both edges of the slot
                ST_DROP: begin
                    if (r_reg < edge_count_reg) begin
                        if (edge_slot_reg[r_idx] != cur_reg) begin
                            edge_pos_reg[w_idx]  <= edge_pos_reg[r_idx];
                            edge_slot_reg[w_idx] <= edge_slot_reg[r_idx];
                            edge_beg_reg[w_idx]  <= edge_beg_reg[r_idx];
                            w_reg                <= w_reg + 1'b1;
                        end
                        r_reg <= r_reg + 1'b1;
                    end else begin
                        edge_count_reg <= w_reg;
                        if (kind_reg == K_UPDATE) begin
                            slot_ylo_reg[cur_reg]   <= by_reg;
                            slot_yhi_reg[cur_reg]   <= ty_reg;
                            slot_stamp_reg[cur_reg] <= stamp_counter_reg;
                            stamp_counter_reg       <= stamp_counter_reg + 1'b1;
                            i_reg                   <= w_reg;
                            state_reg               <= ST_PUT;
                        end else begin
                            slot_valid_reg[cur_reg] <= 1'b0;
                            resp_reg                <= STAT_DONE;
                            state_reg               <= ST_RESP;
                        end
                    end
                end
                // Insertion step: shift one larger edge up, or place the new one
                ST_PUT: begin
                    if (i_reg != '0 && lt) begin
                        edge_pos_reg[i_idx]  <= edge_pos_reg[i_m1];
                        edge_slot_reg[i_idx] <= edge_slot_reg[i_m1];
                        edge_beg_reg[i_idx]  <= edge_beg_reg[i_m1];
                        i_reg                <= i_reg - 1'b1;
                    end else begin
                        edge_pos_reg[i_idx]  <= new_pos;
                        edge_slot_reg[i_idx] <= cur_reg;
                        edge_beg_reg[i_idx]  <= !phase_reg;
                        edge_count_reg       <= edge_count_reg + 1'b1;
                        if (!phase_reg) begin
                            phase_reg <= 1'b1;
                            i_reg     <= edge_count_reg + 1'b1;
                        end else begin
                            resp_reg  <= STAT_DONE;
                            state_reg <= ST_RESP;
                        end
                    end
                end
                // Rank each valid slot by (stamp, slot), one compare a cycle
                ST_RANK: begin
                    if (u_reg == SLOT_W'(N - 1)) begin
                        if (slot_valid_reg[t_reg]) begin
                            ord_reg[rank_fin[SLOT_W-1:0]] <= t_reg;
                        end
                        rank_reg <= '0;
                        u_reg    <= '0;
                        if (t_reg == SLOT_W'(N - 1)) begin
                            e_reg     <= '0;
                            state_reg <= ST_SWEEP;
                        end else begin
                            t_reg <= t_reg + 1'b1;
                        end
                    end else begin
                        rank_reg <= rank_fin;
                        u_reg    <= u_reg + 1'b1;
                    end
                end
                // Advance through the sorted edges
                ST_SWEEP: begin
                    if (e_reg == edge_count_reg) begin
                        state_reg <= ST_QEND;
                    end else if (edge_beg_reg[e_idx]) begin
                        cur_reg   <= edge_slot_reg[e_idx];
                        k_reg     <= '0;
                        state_reg <= ST_CAND;
                    end else begin
                        active_mask_reg[edge_slot_reg[e_idx]] <= 1'b0;
                        e_reg <= e_reg + 1'b1;
                    end
                end
                // Next active interval in stamp order, first y test
                ST_CAND: begin
                    if (k_reg == vcnt_reg) begin
                        active_mask_reg[cur_reg] <= 1'b1;
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= ST_SWEEP;
                    end else if (active_mask_reg[a_slot] && lt) begin
                        state_reg <= ST_Y2;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                // Second y test
                ST_Y2: begin
                    if (lt && pairs_reg < PAIR_W'(MAX_PAIRS)) begin
                        state_reg <= ST_PAIR;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_CAND;
                    end
                end
                // Release the held pair, hold the new one
                ST_PAIR: begin
                    if (!pend_valid_reg || out_free) begin
                        pend_valid_reg  <= 1'b1;
                        pend_first_reg  <= slot_handle_reg[cur_reg];
                        pend_second_reg <= slot_handle_reg[a_slot];
                        pairs_reg       <= pairs_reg + 1'b1;
                        k_reg           <= k_reg + 1'b1;
                        state_reg       <= ST_CAND;
                    end
                end
                // Final query result
                ST_QEND: begin
                    if (out_free) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/sweep_prune_overlap_pairs_top.sv =====
// Top level of the sweep-and-prune overlap pair block: sequencer plus output register.
// Depends on spo_pkg and spo_ctrl.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | kind, object_id, left_x, right_x, bottom_y, top_y
//  m_      | out       | m_valid / m_ready  | status, first_id, second_id, last
//
// Insert places the begin and end edges by insertion shifts, remove compacts the edge list,
// and update does both. A pairs query first ranks the valid slots by stamp, then per begin edge
// steps through each valid slot on the one shared comparator.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled m_ready holds the sequencer at its next result; s_ready is high only when idle.
module sweep_prune_overlap_pairs_top import spo_pkg::*; #(
    parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic [ID_WIDTH-1:0]    s_object_id,
    input  logic [COORD_WIDTH-1:0] s_left_x,
    input  logic [COORD_WIDTH-1:0] s_right_x,
    input  logic [COORD_WIDTH-1:0] s_bottom_y,
    input  logic [COORD_WIDTH-1:0] s_top_y,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [ID_WIDTH-1:0]    m_first_id,
    output logic [ID_WIDTH-1:0]    m_second_id,
    output logic                   m_last
);

    push_t               push;
    logic [ID_WIDTH-1:0] push_first, push_second;
    logic                out_free;

    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [ID_WIDTH-1:0] m_first_reg, m_second_reg;
    logic                m_last_reg;

    assign out_free = !m_valid_reg || m_ready;

    spo_ctrl #(
        .MAX_OBJECTS(MAX_OBJECTS),
        .COORD_WIDTH(COORD_WIDTH),
        .ID_WIDTH(ID_WIDTH)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_object_id(s_object_id),
        .s_left_x(s_left_x),
        .s_right_x(s_right_x),
        .s_bottom_y(s_bottom_y),
        .s_top_y(s_top_y),
        .out_free(out_free),
        .push(push),
        .push_first(push_first),
        .push_second(push_second)
    );

    // Output register: load on push, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.push) begin
            m_valid_reg  <= 1'b1;
            m_status_reg <= push.status;
            m_first_reg  <= push_first;
            m_second_reg <= push_second;
            m_last_reg   <= push.last;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_first_id  = m_first_reg;
    assign m_second_id = m_second_reg;
    assign m_last      = m_last_reg;

endmodule

// ===== sv/spo_checker.sv =====
// Port-level checks of the sweep-and-prune overlap pair block, bound to the top level.
// Depends on spo_pkg.
module spo_checker import spo_pkg::*; #(
    parameter int ID_WIDTH = DEF_ID_WIDTH
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [2:0]          m_status,
    input logic [ID_WIDTH-1:0] m_first_id,
    input logic [ID_WIDTH-1:0] m_second_id,
    input logic                m_last
);

    // Block goes busy after taking a request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after a request");

    // Only pairs may be followed by more results
    a_nonlast_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_status == STAT_PAIR)
        else $error("non-final result is not a pair");

    // No new request while a query is still producing pairs
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("request taken during pair output");

    // Non-pair results carry zero ids
    a_zero_ids: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_PAIR |-> m_first_id == '0 && m_second_id == '0)
        else $error("ids set on a non-pair result");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

endmodule

bind sweep_prune_overlap_pairs_top spo_checker #(.ID_WIDTH(ID_WIDTH)) u_spo_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_status(m_status),
    .m_first_id(m_first_id),
    .m_second_id(m_second_id),
    .m_last(m_last)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sweep-and-prune overlap pair block.
// Depends on spo_pkg and sweep_prune_overlap_pairs_top; models the rectangle table itself.
`timescale 1ns / 1ps

module tb_top;
    import spo_pkg::*;

    localparam int NOBJ = DEF_MAX_OBJECTS;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        status_t    status;
        logic [7:0] first_id;
        logic [7:0] second_id;
        logic       last;
    } pair_result_t;

    typedef struct {
        logic signed [15:0] pos;
        int                 slot;
        bit                 is_begin;
    } edge_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [7:0]  s_object_id = '0;
    logic [15:0] s_left_x = '0, s_right_x = '0, s_bottom_y = '0, s_top_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [7:0]  m_first_id, m_second_id;
    logic        m_last;

    sweep_prune_overlap_pairs_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_object_id(s_object_id), .s_left_x(s_left_x), .s_right_x(s_right_x),
        .s_bottom_y(s_bottom_y), .s_top_y(s_top_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_first_id(m_first_id), .m_second_id(m_second_id), .m_last(m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the rectangle table
    bit                 tbl_used[NOBJ];
    logic [7:0]         tbl_handle[NOBJ];
    logic signed [15:0] tbl_bottom[NOBJ], tbl_top[NOBJ];
    logic [31:0]        tbl_stamp[NOBJ];
    edge_rec_t          sorted_edges[$];
    logic [31:0]        next_stamp = '0;

    pair_result_t expected_results[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           timed_out = 1'b0;

    // Receiver pacing: results taken so far, and the wait drawn for the next one
    int           rx_count = 0;
    int           rx_seen = 0;
    int           rx_wait = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic int lookup_slot(input logic [7:0] id);
        for (int s = 0; s < NOBJ; s++)
            if (tbl_used[s] && tbl_handle[s] == id) return s;
        return -1;
    endfunction

    // Insert after any edge at equal position
    function automatic void insert_edge(input logic signed [15:0] pos, input int slot,
                                        input bit is_begin);
        edge_rec_t e;
        int i;
        e.pos = pos; e.slot = slot; e.is_begin = is_begin;
        i = sorted_edges.size();
        while (i > 0 && sorted_edges[i-1].pos > pos) i--;
        sorted_edges.insert(i, e);
    endfunction

    function automatic void place_rect(input int s, input logic [7:0] id,
                                       input logic [15:0] lx, rx, by, ty);
        tbl_used[s] = 1'b1; tbl_handle[s] = id;
        tbl_bottom[s] = by; tbl_top[s] = ty;
        tbl_stamp[s] = next_stamp;
        next_stamp++;
        insert_edge(lx, s, 1'b1);
        insert_edge(rx, s, 1'b0);
    endfunction

    function automatic void push_result(input status_t st, input logic [7:0] f, sc);
        pair_result_t r;
        r.status = st; r.first_id = f; r.second_id = sc; r.last = 1'b0;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic bit older_slot(input int a, input int b);
        if (tbl_stamp[a] != tbl_stamp[b]) return tbl_stamp[a] < tbl_stamp[b];
        return a < b;
    endfunction

    // Sweep the edge list and collect overlapping pairs
    function automatic int sweep_pairs();
        bit active[NOBJ];
        int order[$];
        int n, s, a, i;
        n = 0;
        foreach (active[t]) active[t] = 1'b0;
        foreach (sorted_edges[e]) begin
            s = sorted_edges[e].slot;
            if (sorted_edges[e].is_begin) begin
                order.delete();
                for (int t = 0; t < NOBJ; t++) begin
                    if (!active[t]) continue;
                    i = order.size();
                    while (i > 0 && older_slot(t, order[i-1])) i--;
                    order.insert(i, t);
                end
                foreach (order[k]) begin
                    a = order[k];
                    if (tbl_bottom[a] < tbl_top[s] && tbl_bottom[s] < tbl_top[a]
                        && n < MAX_PAIRS) begin
                        push_result(STAT_PAIR, tbl_handle[s], tbl_handle[a]);
                        n++;
                    end
                end
                active[s] = 1'b1;
            end else begin
                active[s] = 1'b0;
            end
        end
        return n;
    endfunction

    function automatic void predict_request(input kind_t kind, input logic [7:0] id,
                                            input logic [15:0] lx, rx, by, ty);
        int s, t;
        s = lookup_slot(id);
        if (kind == K_QUERY) begin
            if (sweep_pairs() == 0) push_result(STAT_NONE, 8'd0, 8'd0);
        end else if (kind == K_INSERT) begin
            t = 0;
            while (t < NOBJ && tbl_used[t]) t++;
            if (s >= 0 || t >= NOBJ) push_result(STAT_REJECT, 8'd0, 8'd0);
            else begin
                place_rect(t, id, lx, rx, by, ty);
                push_result(STAT_DONE, 8'd0, 8'd0);
            end
        end else if (s < 0) begin
            push_result(STAT_ABSENT, 8'd0, 8'd0);
        end else begin
            for (int e = sorted_edges.size() - 1; e >= 0; e--)
                if (sorted_edges[e].slot == s) sorted_edges.delete(e);
            tbl_used[s] = 1'b0;
            if (kind == K_UPDATE) place_rect(s, id, lx, rx, by, ty);
            push_result(STAT_DONE, 8'd0, 8'd0);
        end
        expected_results[expected_results.size()-1].last = 1'b1;
    endfunction

    // Send one request after a random gap, predicting on acceptance
    task automatic send_request(input kind_t kind, input logic [7:0] id,
                                input logic [15:0] lx, rx, by, ty);
        int gap;
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(11);
        repeat (gap + 1) @(negedge aclk);
        s_valid <= 1'b1; s_kind <= kind; s_object_id <= id;
        s_left_x <= lx; s_right_x <= rx; s_bottom_y <= by; s_top_y <= ty;
        do @(posedge aclk); while (!s_ready);
        predict_request(kind, id, lx, rx, by, ty);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Hold off until every expected result has arrived
    task automatic drain_results();
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    task automatic send_random_rect(input kind_t kind, input logic [7:0] id);
        logic [15:0] a, b, c, d;
        a = 16'($urandom_range(200)) - 16'd100; b = a + 16'($urandom_range(80));
        c = 16'($urandom_range(200)) - 16'd100; d = c + 16'($urandom_range(80));
        if ($urandom_range(9) == 0) b = 16'($urandom);
        if ($urandom_range(9) == 0) begin c = 16'($urandom); d = 16'($urandom); end
        send_request(kind, id, a, b, c, d);
    endtask

    // Receiver: draw a wait for each result, then raise ready
    always @(negedge aclk) begin
        if (rx_seen != rx_count) begin
            rx_seen = rx_count;
            rx_wait = $urandom_range(11);
        end
        if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result field by field
    always @(posedge aclk) begin
        pair_result_t want;
        if (aresetn && m_valid && m_ready) begin
            rx_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request waiting");
            end else begin
                want = expected_results.pop_front();
                if (m_status != want.status)
                    report_mismatch($sformatf("status %0d want %0d", m_status, want.status));
                if (m_first_id != want.first_id)
                    report_mismatch($sformatf("first_id %0d want %0d", m_first_id,
                                              want.first_id));
                if (m_second_id != want.second_id)
                    report_mismatch($sformatf("second_id %0d want %0d", m_second_id,
                                              want.second_id));
                if (m_last != want.last)
                    report_mismatch($sformatf("last %0b want %0b", m_last, want.last));
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("sweep_prune_overlap_pairs_top verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(K_QUERY, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(K_REMOVE, 8'd5, '0, '0, '0, '0);
        send_request(K_UPDATE, 8'd5, '0, '0, '0, '0);
        send_request(K_INSERT, 8'd255, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_request(K_INSERT, 8'd0, 16'h8000, 16'h0000, 16'h0000, 16'h7fff);
        send_request(K_INSERT, 8'd255, 16'd0, 16'd1, 16'd0, 16'd1);
        // touching y spans do not overlap
        send_request(K_INSERT, 8'd7, 16'd0, 16'd10, 16'h7fff, 16'h7fff);
        send_request(K_INSERT, 8'd8, 16'd10, 16'd5, 16'd0, 16'd100);
        send_request(K_INSERT, 8'd9, 16'd10, 16'd20, 16'hfff0, 16'd10);
        send_request(K_QUERY, 8'd0, '0, '0, '0, '0);
        send_request(K_UPDATE, 8'd0, 16'd5, 16'd15, 16'd1, 16'd50);
        send_request(K_INSERT, 8'd10, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(K_INSERT, 8'd11, 16'd1, 16'd1, 16'd1, 16'd1);
        send_request(K_INSERT, 8'd12, 16'd2, 16'd2, 16'd2, 16'd2);
        send_request(K_INSERT, 8'd13, 16'd3, 16'd3, 16'd3, 16'd3);
        send_request(K_QUERY, 8'd0, '0, '0, '0, '0);
        send_request(K_REMOVE, 8'd255, '0, '0, '0, '0);
        send_request(K_REMOVE, 8'd255, '0, '0, '0, '0);
        send_request(K_QUERY, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        drain_results();
    endtask

    task automatic test_random();
        kind_t k;
        logic [7:0] id;
        for (int n = 0; n < 300; n++) begin
            case ($urandom_range(9))
                0, 1, 2: k = K_INSERT;
                3, 4:    k = K_REMOVE;
                5, 6:    k = K_UPDATE;
                default: k = K_QUERY;
            endcase
            // small id pool so hits dominate, occasional full-range ids
            id = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(11));
            if (k == K_QUERY)
                send_request(k, 8'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
            else send_random_rect(k, id);
            if (n == 150) drain_results();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        drain_results();
        repeat (50) @(posedge aclk);
        if (error_count == 0) $display("sweep_prune_overlap_pairs_top verification clean");
        else $display("sweep_prune_overlap_pairs_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/spo_pkg.sv
sv/spo_cmp.sv
sv/spo_ctrl.sv
sv/sweep_prune_overlap_pairs_top.sv
sv/spo_checker.sv
tb/tb_top.sv
